// ===== hdl/bump_pointer_allocator_macros.svh =====
// assertion macros shared by the checker of the bump pointer allocator
// depends on nothing; included by bpa_checker.sv
`ifndef BUMP_POINTER_ALLOCATOR_MACROS_SVH
`define BUMP_POINTER_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bump pointer allocator check failed");

// next-cycle implication, disabled while reset is low
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bump pointer allocator check failed");

`endif

// ===== hdl/bpa_pkg.sv =====
// types and constants of the bump pointer allocator
// depends on nothing; imported by bpa_ifs, bpa_front, bpa_back, the top level and bpa_checker
`default_nettype none

package bpa_pkg;

    localparam int unsigned FILLER_BYTES = 12;

    typedef enum logic [2:0] {
        OP_SET_CONTEXT     = 3'd0,
        OP_OBJECT          = 3'd1,
        OP_ARRAY           = 3'd2,
        OP_OBJECT_ALIGN8   = 3'd3,
        OP_OBJECT_MISALIGN = 3'd4,
        OP_ARRAY_ALIGN8    = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_SLOW     = 2'd2,
        ST_CONTEXT  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        KIND_CTX   = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PAD_NONE     = 2'd0,
        PAD_ALIGN8   = 2'd1,
        PAD_MISALIGN = 2'd2
    } t_pad_mode;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [15:0]        base_size;
        logic [15:0]        component_size;
        logic signed [31:0] element_count;
        logic               has_finalizer;
        logic [31:0]        new_pointer;
        logic [31:0]        new_limit;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] object_address;
        logic        filler_placed;
        logic [31:0] filler_address;
    } t_rsp;

    // classified request as it travels from front to back
    typedef struct packed {
        t_kind       kind;
        t_status     status;
        t_pad_mode   mode;
        logic [31:0] new_pointer;
        logic [31:0] new_limit;
    } t_ctl;

endpackage

`default_nettype wire

// ===== hdl/bpa_ifs.sv =====
// valid/ready channel interfaces for requests and responses
// depends on bpa_pkg
`default_nettype none

interface bpa_req_if;
    import bpa_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bpa_rsp_if;
    import bpa_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bpa_front.sv =====
// front end: accepts requests, classifies them, multiplies count by component size
// and forms the unpadded byte size; depends on bpa_pkg and bpa_ifs
`default_nettype none

module bpa_front #(
    parameter int FAST_COUNT_MAX = 65536,
    parameter int SIZE_W         = 35
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    bpa_req_if.sink                 i_req,
    output logic                    o_valid,
    output bpa_pkg::t_ctl           o_ctl,
    output logic [SIZE_W-1:0]       o_size,
    input  wire                     i_ready
);
    import bpa_pkg::*;

    localparam int CNT_W  = $clog2(FAST_COUNT_MAX + 1);
    localparam int PROD_W = CNT_W + 16;

    logic              r_valid;
    t_ctl              r_ctl;
    logic              r_is_array;
    logic              r_round;
    logic [15:0]       r_base;
    logic [PROD_W-1:0] r_prod;

    t_ctl              n_ctl;
    logic              n_is_array;
    logic              n_round;
    logic              push;
    logic [SIZE_W-1:0] sum;

    assign push        = r_valid && i_ready;
    assign i_req.ready = !r_valid || push;

    always_comb begin
        n_ctl             = '0;
        n_ctl.kind        = KIND_DONE;
        n_ctl.status      = ST_SLOW;
        n_ctl.mode        = PAD_NONE;
        n_ctl.new_pointer = i_req.data.new_pointer;
        n_ctl.new_limit   = i_req.data.new_limit;
        n_is_array        = 1'b0;
        n_round           = 1'b0;
        case (t_opcode'(i_req.data.opcode))
            OP_SET_CONTEXT: begin
                n_ctl.kind   = KIND_CTX;
                n_ctl.status = ST_CONTEXT;
            end
            OP_OBJECT, OP_OBJECT_ALIGN8, OP_OBJECT_MISALIGN: begin
                if (!i_req.data.has_finalizer) begin
                    n_ctl.kind = KIND_ALLOC;
                    if (i_req.data.opcode == OP_OBJECT_ALIGN8) begin
                        n_ctl.mode = PAD_ALIGN8;
                        n_round    = 1'b1;
                    end else if (i_req.data.opcode == OP_OBJECT_MISALIGN) begin
                        n_ctl.mode = PAD_MISALIGN;
                    end
                end
            end
            OP_ARRAY, OP_ARRAY_ALIGN8: begin
                if (i_req.data.element_count[31]) begin
                    n_ctl.status = ST_OVERFLOW;
                end else if ($unsigned(i_req.data.element_count) > 32'(FAST_COUNT_MAX)) begin
                    n_ctl.status = ST_SLOW;
                end else begin
                    n_ctl.kind = KIND_ALLOC;
                    n_is_array = 1'b1;
                    n_round    = 1'b1;
                    if (i_req.data.opcode == OP_ARRAY_ALIGN8) begin
                        n_ctl.mode = PAD_ALIGN8;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_ctl      <= n_ctl;
            r_is_array <= n_is_array;
            r_round    <= n_round;
            r_base     <= i_req.data.base_size;
            r_prod     <= PROD_W'(i_req.data.element_count[CNT_W-1:0])
                          * PROD_W'(i_req.data.component_size);
        end
    end

    // base plus array payload, rounded up to a multiple of four when needed
    assign sum = SIZE_W'(r_base) + (r_is_array ? SIZE_W'(r_prod) : SIZE_W'(0));

    always_comb begin
        o_size = sum;
        if (r_round) begin
            o_size = (sum + SIZE_W'(3)) & ~SIZE_W'(3);
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;

endmodule

`default_nettype wire

// ===== hdl/bpa_queue.sv =====
// small first-in first-out queue between the front and back ends
// depends on nothing
`default_nettype none

module bpa_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire [WIDTH-1:0]  i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  wire              i_pop
);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [IDX_W-1:0] r_wptr;
    logic [IDX_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == IDX_W'(DEPTH - 1)) ? '0 : r_wptr + IDX_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == IDX_W'(DEPTH - 1)) ? '0 : r_rptr + IDX_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bpa_back.sv =====
// back end: holds pointer and limit, decides padding and fit, drives the response register
// depends on bpa_pkg and bpa_ifs
`default_nettype none

module bpa_back #(
    parameter int ADDR_WIDTH = 32,
    parameter int SIZE_W     = 35
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    input  wire bpa_pkg::t_ctl      i_ctl,
    input  wire [SIZE_W-1:0]        i_size,
    output logic                    o_pop,
    bpa_rsp_if.source               o_rsp
);
    import bpa_pkg::*;

    localparam int AW    = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
    localparam int CMP_W = (SIZE_W > AW) ? SIZE_W : AW;

    logic [AW-1:0]     r_ptr;
    logic [AW-1:0]     r_limit;
    logic              r_out_valid;
    t_rsp              r_out;

    logic [AW-1:0]     n_ptr;
    logic [AW-1:0]     n_limit;
    t_rsp              n_out;
    logic              pad;
    logic [SIZE_W-1:0] total;
    logic [AW-1:0]     room;
    logic              fits;
    logic [AW-1:0]     obj_addr;

    assign o_pop = i_valid && (!r_out_valid || o_rsp.ready);

    always_comb begin
        case (i_ctl.mode)
            PAD_ALIGN8:   pad = (r_ptr[2:0] != 3'd0);
            PAD_MISALIGN: pad = (r_ptr[2:0] != 3'd4);
            default:      pad = 1'b0;
        endcase
    end

    assign total    = i_size + (pad ? SIZE_W'(FILLER_BYTES) : SIZE_W'(0));
    assign room     = (r_ptr <= r_limit) ? (r_limit - r_ptr) : '0;
    assign fits     = CMP_W'(room) >= CMP_W'(total);
    assign obj_addr = r_ptr + AW'(FILLER_BYTES);

    always_comb begin
        n_ptr        = r_ptr;
        n_limit      = r_limit;
        n_out        = '0;
        n_out.status = i_ctl.status;
        case (i_ctl.kind)
            KIND_CTX: begin
                n_ptr   = AW'(i_ctl.new_pointer);
                n_limit = AW'(i_ctl.new_limit);
            end
            KIND_ALLOC: begin
                if (fits) begin
                    n_out.status         = ST_GRANTED;
                    n_out.object_address = 32'(pad ? obj_addr : r_ptr);
                    n_out.filler_placed  = pad;
                    n_out.filler_address = pad ? 32'(r_ptr) : 32'd0;
                    n_ptr                = r_ptr + AW'(total);
                end else begin
                    n_out.status = ST_SLOW;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_limit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_ptr   <= n_ptr;
                r_limit <= n_limit;
            end
            if (!r_out_valid || o_rsp.ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

`default_nettype wire

// ===== hdl/bump_pointer_allocator.sv =====
// bump pointer allocator, fast path
// top level: front end, queue and back end; depends on bpa_pkg, bpa_ifs,
// bpa_front, bpa_queue and bpa_back
//
// i_req carries one request beat per valid/ready handshake: set context,
// object, array and their aligned variants. o_rsp returns exactly one beat
// per request, in order: a status plus the object and filler addresses.
// o_rsp.valid rises once a request has passed the front register (class and
// count times component size) and the two-entry queue, from whose head the
// back end settles pointer, padding and fit and loads the response register.
// One beat is accepted every cycle while o_rsp.ready is high; the pointer
// update in the back end is the only loop.
// Reset clears pointer and limit to zero and empties all stages.
// When the receiver stalls, the response register holds, the queue and then
// the front register fill, and i_req.ready drops once four beats are held:
// the stalled response, two queue entries and the front register.
`default_nettype none

module bump_pointer_allocator #(
    parameter int ADDR_WIDTH     = 32,
    parameter int FAST_COUNT_MAX = 65536
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    bpa_req_if.sink   i_req,
    bpa_rsp_if.source o_rsp
);
    import bpa_pkg::*;

    localparam int CNT_W   = $clog2(FAST_COUNT_MAX + 1);
    localparam int SIZE_W  = CNT_W + 18;
    localparam int ENTRY_W = $bits(t_ctl) + SIZE_W;

    logic              fe_valid;
    t_ctl              fe_ctl;
    logic [SIZE_W-1:0] fe_size;
    logic              q_ready;
    logic              q_valid;
    logic [ENTRY_W-1:0] q_data;
    t_ctl              be_ctl;
    logic [SIZE_W-1:0] be_size;
    logic              be_pop;

    bpa_front #(
        .FAST_COUNT_MAX (FAST_COUNT_MAX),
        .SIZE_W         (SIZE_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_valid (fe_valid),
        .o_ctl   (fe_ctl),
        .o_size  (fe_size),
        .i_ready (q_ready)
    );

    bpa_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_valid),
        .i_data  ({fe_ctl, fe_size}),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (be_pop)
    );

    assign be_ctl  = t_ctl'(q_data[ENTRY_W-1:SIZE_W]);
    assign be_size = q_data[SIZE_W-1:0];

    bpa_back #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .SIZE_W     (SIZE_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_ctl   (be_ctl),
        .i_size  (be_size),
        .o_pop   (be_pop),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

// ===== hdl/bpa_checker.sv =====
// port-level checker for the bump pointer allocator response channel, with its bind
// depends on bpa_pkg and bump_pointer_allocator_macros.svh
`default_nettype none
`include "bump_pointer_allocator_macros.svh"

module bpa_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_rsp_valid,
    input wire                i_rsp_ready,
    input wire bpa_pkg::t_rsp i_rsp_data
);
    import bpa_pkg::*;

    // a stalled beat holds
    `BPA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_data))

    // anything but a grant carries no addresses
    `BPA_ASSERT_NOW(a_no_grant_zero, i_clk, i_rst_n, i_rsp_valid && i_rsp_data.status != ST_GRANTED, i_rsp_data.object_address == 32'd0 && !i_rsp_data.filler_placed && i_rsp_data.filler_address == 32'd0)

    // filler only on a grant, object twelve bytes on keeps the low bits
    `BPA_ASSERT_NOW(a_filler_grant, i_clk, i_rst_n, i_rsp_valid && i_rsp_data.filler_placed, i_rsp_data.status == ST_GRANTED && i_rsp_data.object_address[1:0] == i_rsp_data.filler_address[1:0])

    // no filler, no filler address
    `BPA_ASSERT_NOW(a_filler_addr, i_clk, i_rst_n, i_rsp_valid && !i_rsp_data.filler_placed, i_rsp_data.filler_address == 32'd0)

endmodule

bind bump_pointer_allocator bpa_checker u_bpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

`default_nettype wire
